@@ hdl/alfr_pkg.sv @@
// shared constants, types and helpers for the additive lagged fibonacci generator
package alfr_pkg;

   localparam int TABLE_DEGREE   = 31;
   localparam int TAP_SEPARATION = 3;
   localparam int WARMUP_ROUNDS  = 10;
   localparam int WARMUP_DRAWS   = TABLE_DEGREE * WARMUP_ROUNDS;

   localparam int MS_MULT = 16807;
   localparam int MS_QUOT = 127773;
   localparam int MS_REM  = 2836;
   localparam int MS_MOD  = 2147483647;

   localparam int WORD_W   = 32;
   localparam int RAND_W   = 31;
   localparam int X_W      = 33;
   localparam int IDX_W    = $clog2(TABLE_DEGREE);
   localparam int WARM_W   = $clog2(WARMUP_DRAWS);
   localparam int QUO_W    = 15;
   localparam int REM_W    = $clog2(MS_QUOT);
   localparam int P2_W     = 27;
   localparam int RECIP_SH = 48;

   // ceil(2^48 / 127773), exact quotient for dividends up to 2^31
   localparam logic [WORD_W-1:0] RECIP_MUL = WORD_W'(
      ((64'd1 << RECIP_SH) + 64'(MS_QUOT) - 64'd1) / 64'(MS_QUOT));

   localparam logic REQ_DRAW   = 1'b0;
   localparam logic REQ_RESEED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED0,
      ST_DIV_LOAD,
      ST_DIV_QUO,
      ST_DIV_REM,
      ST_MULT,
      ST_STORE,
      ST_DRAW_RD,
      ST_DRAW_WR
   } state_type;

   typedef struct packed {
      logic             seed_cap;
      logic             seed_one;
      logic             seed_wr0;
      logic             div_load;
      logic             div_quo;
      logic             div_rem;
      logic             mult;
      logic             store;
      logic             draw_wr;
      logic             rsp_load;
      logic [IDX_W-1:0] tbl_idx;
   } cmd_type;

   function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(TABLE_DEGREE - 1)) begin
         r = '0;
      end else begin
         r = i + IDX_W'(1);
      end
      return r;
   endfunction

endpackage

@@ hdl/alfr_ram.sv @@
// generic ram, one write port and two registered read ports
module alfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/alfr_dp.sv @@
// datapath: seed arithmetic, lag table and result register
module alfr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  alfr_pkg::cmd_type      cmd,
   input  logic [31:0]            req_seed_value,
   output logic [30:0]            rsp_rand_value
);
   import alfr_pkg::*;

   logic [WORD_W-1:0]       seed_ff, seed_in;
   logic signed [X_W-1:0]   x_ff, x_in;
   logic [WORD_W-1:0]       mag_ff, mag_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic [WORD_W-1:0]       p1_ff, p1_in;
   logic [P2_W-1:0]         p2_ff, p2_in;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [IDX_W-1:0]        rear_ff, rear_in;
   logic [RAND_W-1:0]       rand_ff, rand_in;

   logic [WORD_W-1:0]       abs_x;
   logic [2*WORD_W-1:0]     recip_prod;
   logic [WORD_W-1:0]       quo_back;
   logic signed [X_W-1:0]   diff;
   logic signed [X_W-1:0]   signed_t;
   logic signed [X_W-1:0]   fixed_t;
   logic [WORD_W-1:0]       word_a, word_b, sum;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [WORD_W-1:0]       wr_data;

   always_comb begin
      abs_x      = x_ff[X_W-1] ? WORD_W'(-x_ff) : x_ff[WORD_W-1:0];
      recip_prod = (2*WORD_W)'(mag_ff) * (2*WORD_W)'(RECIP_MUL);
      quo_back   = WORD_W'(WORD_W'(quo_ff) * WORD_W'(MS_QUOT));
      diff     = $signed({1'b0, p1_ff}) - $signed({{(X_W - P2_W){1'b0}}, p2_ff});
      signed_t = neg_ff ? -diff : diff;
      fixed_t  = signed_t[X_W-1] ? signed_t + X_W'(MS_MOD) : signed_t;
      sum      = word_a + word_b;

      seed_in  = seed_ff;
      x_in     = x_ff;
      mag_in   = mag_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      front_in = front_ff;
      rear_in  = rear_ff;
      rand_in  = rand_ff;

      if (cmd.seed_cap) begin
         if (cmd.seed_one || req_seed_value == '0) begin
            seed_in = WORD_W'(1);
         end else begin
            seed_in = req_seed_value;
         end
      end
      if (cmd.seed_wr0) begin
         x_in     = $signed({seed_ff[WORD_W-1], seed_ff});
         front_in = IDX_W'(TAP_SEPARATION);
         rear_in  = '0;
      end
      if (cmd.div_load) begin
         mag_in = abs_x;
         neg_in = x_ff[X_W-1];
      end
      if (cmd.div_quo) begin
         quo_in = recip_prod[RECIP_SH +: QUO_W];
      end
      if (cmd.div_rem) begin
         rem_in = REM_W'(mag_ff - quo_back);
      end
      if (cmd.mult) begin
         p1_in = WORD_W'(WORD_W'(rem_ff) * WORD_W'(MS_MULT));
         p2_in = P2_W'(P2_W'(quo_ff) * P2_W'(MS_REM));
      end
      if (cmd.store) begin
         x_in = fixed_t;
      end
      if (cmd.draw_wr) begin
         front_in = adv_idx(front_ff);
         rear_in  = adv_idx(rear_ff);
      end
      if (cmd.rsp_load) begin
         rand_in = sum[WORD_W-1:1];
      end

      wr_en   = cmd.seed_wr0 | cmd.store | cmd.draw_wr;
      wr_addr = cmd.draw_wr ? front_ff : cmd.tbl_idx;
      if (cmd.draw_wr) begin
         wr_data = sum;
      end else if (cmd.store) begin
         wr_data = fixed_t[WORD_W-1:0];
      end else begin
         wr_data = seed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= IDX_W'(TAP_SEPARATION);
         rear_ff  <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
      seed_ff <= seed_in;
      x_ff    <= x_in;
      mag_ff  <= mag_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      rand_ff <= rand_in;
   end

   alfr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_DEGREE)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (front_ff),
      .rd_addr_b (rear_ff),
      .rd_data_a (word_a),
      .rd_data_b (word_b)
   );

   assign rsp_rand_value = rand_ff;

endmodule

@@ hdl/alfr_ctrl.sv @@
// controller: sequences seeding, warmup draws and result beats
module alfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alfr_pkg::cmd_type cmd
);
   import alfr_pkg::*;

   state_type          state_ff, state_in;
   logic               seeded_ff, seeded_in;
   logic               pend_ff, pend_in;
   logic               user_ff, user_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [WARM_W-1:0]  warm_ff, warm_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         user_ff      <= 1'b0;
         idx_ff       <= '0;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         pend_ff      <= pend_in;
         user_ff      <= user_in;
         idx_ff       <= idx_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      seeded_in   = seeded_ff;
      pend_in     = pend_ff;
      user_in     = user_ff;
      idx_in      = idx_ff;
      warm_in     = warm_ff;
      cmd         = '0;
      cmd.tbl_idx = idx_ff;
      req_stall   = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_RESEED) begin
                  cmd.seed_cap = 1'b1;
                  pend_in      = 1'b0;
                  state_in     = ST_SEED0;
               end else if (seeded_ff) begin
                  user_in  = 1'b1;
                  state_in = ST_DRAW_RD;
               end else begin
                  cmd.seed_cap = 1'b1;
                  cmd.seed_one = 1'b1;
                  pend_in      = 1'b1;
                  state_in     = ST_SEED0;
               end
            end
         end
         ST_SEED0: begin
            cmd.seed_wr0 = 1'b1;
            cmd.tbl_idx  = '0;
            seeded_in    = 1'b1;
            idx_in       = IDX_W'(1);
            state_in     = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_QUO;
         end
         ST_DIV_QUO: begin
            cmd.div_quo = 1'b1;
            state_in    = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            cmd.div_rem = 1'b1;
            state_in    = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (idx_ff == IDX_W'(TABLE_DEGREE - 1)) begin
               warm_in  = '0;
               user_in  = 1'b0;
               state_in = ST_DRAW_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DRAW_RD: begin
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            if (!user_ff || !rsp_valid_ff || !rsp_stall) begin
               cmd.draw_wr = 1'b1;
               if (user_ff) begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  warm_in = warm_ff + WARM_W'(1);
                  if (warm_ff == WARM_W'(WARMUP_DRAWS - 1)) begin
                     if (pend_ff) begin
                        pend_in  = 1'b0;
                        user_in  = 1'b1;
                        state_in = ST_DRAW_RD;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_DRAW_RD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/additive_lagged_fibonacci_rng.sv @@
// top level of the additive lagged fibonacci random number generator
// usage:
//   request channel (req_valid / req_stall): req_type selects a draw or a
//   reseed; req_seed_value is used on a reseed only, zero acts as one.
//   result channel (rsp_valid / rsp_stall): one beat of rsp_rand_value per
//   draw, none per reseed.
//   a draw holds req_stall high after its beat through a read of both
//   lag words and then the add and write-back, which waits while an
//   earlier result beat is stalled; the result is registered with the
//   write-back. a reseed holds req_stall high through the seed store,
//   then for each of the other 30 table words the magnitude load, a
//   reciprocal multiply for the quotient, the remainder, the two products
//   and the store, then 310 warmup draws, each a read and a write-back.
//   a draw before any reseed first seeds with one, then makes its draw.
//   reset returns the indices to 3 and 0, marks the table unseeded and
//   drops any pending result; the table contents are not cleared.
//   while a result beat is stalled the result register holds it; a new
//   request is still taken, and a following draw waits before its write.
module additive_lagged_fibonacci_rng (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_rand_value
);
   import alfr_pkg::*;

   cmd_type cmd;

   alfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   alfr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_seed_value (req_seed_value),
      .rsp_rand_value (rsp_rand_value)
   );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the additive lagged fibonacci random number generator
`timescale 1ns / 1ps

module testbench;
   import alfr_pkg::*;

   class draw_scoreboard;
      logic [31:0] lag_words [TABLE_DEGREE];
      int          front_pos;
      int          rear_pos;
      bit          seeded;
      logic [30:0] expected_draws [$];
      int          mismatches;

      function new();
         front_pos  = TAP_SEPARATION;
         rear_pos   = 0;
         seeded     = 1'b0;
         mismatches = 0;
      endfunction

      function logic [30:0] step_table();
         logic [31:0] sum;
         sum = lag_words[front_pos] + lag_words[rear_pos];
         lag_words[front_pos] = sum;
         front_pos = (front_pos + 1) % TABLE_DEGREE;
         rear_pos  = (rear_pos + 1) % TABLE_DEGREE;
         return sum[31:1];
      endfunction

      function void fill_table(logic [31:0] seed);
         longint x;
         longint q;
         longint r;
         logic [30:0] unused;
         if (seed == 32'd0) seed = 32'd1;
         lag_words[0] = seed;
         x = longint'($signed(seed));
         for (int i = 1; i < TABLE_DEGREE; i++) begin
            q = x / MS_QUOT;
            r = x % MS_QUOT;
            x = longint'(MS_MULT) * r - longint'(MS_REM) * q;
            if (x < 0) x = x + MS_MOD;
            lag_words[i] = x[31:0];
         end
         front_pos = TAP_SEPARATION;
         rear_pos  = 0;
         seeded    = 1'b1;
         for (int i = 0; i < WARMUP_DRAWS; i++) unused = step_table();
      endfunction

      function void note_request(logic typ, logic [31:0] seed);
         if (typ == REQ_RESEED) begin
            fill_table(seed);
         end else begin
            if (!seeded) fill_table(32'd1);
            expected_draws.push_back(step_table());
         end
      endfunction

      task report_mismatch(string what);
         if (mismatches < 100) $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_draw(logic [30:0] got);
         logic [30:0] want;
         if (expected_draws.size() == 0) begin
            report_mismatch($sformatf("rand_value %h with no draw pending", got));
            return;
         end
         want = expected_draws.pop_front();
         if (got !== want)
            report_mismatch($sformatf("rand_value got %h expected %h", got, want));
      endtask
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_type       = REQ_DRAW;
   logic [31:0] req_seed_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [30:0] rsp_rand_value;

   draw_scoreboard sb = new();
   bit             calm = 1'b0;

   additive_lagged_fibonacci_rng u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rand_value (rsp_rand_value)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_draw(rsp_rand_value);
   end

   task send_request(logic typ, logic [31:0] seed);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= typ;
      req_seed_value <= seed;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(typ, seed);
   endtask

   initial begin
      logic        typ;
      logic [31:0] seed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // draw before any reseed, seed field ignored
      send_request(REQ_DRAW, 32'hFFFF_FFFF);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_DRAW, 32'h8000_0000);
      send_request(REQ_RESEED, 32'h0000_0000);
      send_request(REQ_DRAW, 32'h1234_5678);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, 32'h0000_0001);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, 32'h7FFF_FFFF);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, 32'h8000_0000);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, 32'hFFFF_FFFF);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_DRAW, 32'hFFFF_FFFF);
      send_request(REQ_RESEED, 32'h8000_0001);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, 32'd127773);
      send_request(REQ_DRAW, 32'h0000_0000);
      send_request(REQ_RESEED, -32'sd127773);
      send_request(REQ_DRAW, 32'h0000_0000);
      // back to back reseeds
      send_request(REQ_RESEED, 32'h5555_5555);
      send_request(REQ_RESEED, 32'hAAAA_AAAA);
      send_request(REQ_DRAW, 32'h0000_0000);

      for (int n = 0; n < 700; n++) begin
         calm = (n >= 250 && n < 400);
         typ  = ($urandom_range(99) < 6) ? REQ_RESEED : REQ_DRAW;
         case ($urandom_range(15))
            0:       seed = 32'd0;
            1:       seed = 32'hFFFF_FFFF;
            2:       seed = {1'b1, 31'($urandom_range(255))};
            default: seed = $urandom;
         endcase
         send_request(typ, seed);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.expected_draws.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
